FILE: hdl/sha1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_pkg
// Types and constants shared by the SHA-1 controller, datapath and top level.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam logic [31:0] SHA1_IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] SHA1_K [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	localparam int unsigned NUM_ROUNDS  = 80;
	localparam int unsigned DIGEST_LEN  = 5;
	localparam logic [3:0]  POS_LEN_HI  = 4'd14;
	localparam logic [3:0]  POS_BLK_END = 4'd15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	// padding progress after the final word
	typedef enum logic [2:0] {
		PS_NONE,
		PS_80,
		PS_ZERO,
		PS_LO,
		PS_DONE
	} pad_t;

	// source of the word shifted into the schedule
	typedef enum logic [2:0] {
		WS_IN,
		WS_PAD80,
		WS_ZERO,
		WS_LEN_HI,
		WS_LEN_LO
	} wsel_t;

	typedef enum logic [1:0] {
		RP_CH,
		RP_PAR1,
		RP_MAJ,
		RP_PAR2
	} rphase_t;

	typedef struct packed {
		logic       put;
		wsel_t      wsel;
		logic       len_add;
		logic       load_rounds;
		logic       round;
		rphase_t    rphase;
		logic       add_chain;
		logic       finish;
		logic [2:0] out_idx;
	} cmd_t;

	typedef struct packed {
		logic full_word;
	} sts_t;

endpackage
`default_nettype wire

FILE: hdl/sha1_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: word slot counter, padding steps, round counter, digest readout.
// ----------------------------------------------------------------------------
module sha1_ctrl
	import sha1_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_last,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [6:0] RND_LAST = 7'(NUM_ROUNDS - 1);
	localparam logic [2:0] IDX_LAST = 3'(DIGEST_LEN - 1);

	state_t     state_q, state_d;
	pad_t       pad_q;
	logic [3:0] pos_q;
	logic [6:0] rnd_q;
	logic [2:0] oidx_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (pos_q == POS_BLK_END)
						state_d = ST_ROUND;
					else if (in_last)
						state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (pos_q == POS_BLK_END)
					state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == RND_LAST)
					state_d = ST_ADD;
			end
			ST_ADD: begin
				if (pad_q == PS_NONE)
					state_d = ST_IDLE;
				else if (pad_q == PS_DONE)
					state_d = ST_OUT;
				else
					state_d = ST_PAD;
			end
			ST_OUT: begin
				if (out_ready && oidx_q == IDX_LAST)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		cmd.wsel    = WS_IN;
		cmd.rphase  = RP_CH;
		cmd.out_idx = oidx_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		if (rnd_q < 7'd20)
			cmd.rphase = RP_CH;
		else if (rnd_q < 7'd40)
			cmd.rphase = RP_PAR1;
		else if (rnd_q < 7'd60)
			cmd.rphase = RP_MAJ;
		else
			cmd.rphase = RP_PAR2;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.put     = 1'b1;
					cmd.len_add = 1'b1;
				end
			end
			ST_PAD: begin
				cmd.put = 1'b1;
				if (pad_q == PS_80)
					cmd.wsel = WS_PAD80;
				else if (pad_q == PS_LO)
					cmd.wsel = WS_LEN_LO;
				else if (pos_q == POS_LEN_HI)
					cmd.wsel = WS_LEN_HI;
				else
					cmd.wsel = WS_ZERO;
			end
			ST_ROUND: cmd.round = 1'b1;
			ST_ADD:   cmd.add_chain = 1'b1;
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready && oidx_q == IDX_LAST)
					cmd.finish = 1'b1;
			end
			default: ;
		endcase
		cmd.load_rounds = cmd.put && (pos_q == POS_BLK_END);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pad_q   <= PS_NONE;
			pos_q   <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.put)
				pos_q <= pos_q + 4'd1;
			if (cmd.round)
				rnd_q <= (rnd_q == RND_LAST) ? 7'd0 : rnd_q + 7'd1;
			if (state_q == ST_IDLE && in_valid && in_last)
				pad_q <= sts.full_word ? PS_80 : PS_ZERO;
			else if (state_q == ST_PAD) begin
				if (pad_q == PS_80)
					pad_q <= PS_ZERO;
				else if (pad_q == PS_LO)
					pad_q <= PS_DONE;
				else if (pos_q == POS_LEN_HI)
					pad_q <= PS_LO;
			end else if (cmd.finish)
				pad_q <= PS_NONE;
			if (out_valid && out_ready)
				oidx_q <= (oidx_q == IDX_LAST) ? 3'd0 : oidx_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sha1_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_dp
// Datapath: schedule shift line, working variables, chaining state, length.
// ----------------------------------------------------------------------------
module sha1_dp
	import sha1_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] message_word,
	input  wire logic [2:0]  valid_bytes,
	input  wire logic        last_word,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	output logic [31:0]      digest_word
);

	logic [31:0] chain_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];
	logic [63:0] len_q;

	logic [2:0]  nbytes;
	logic [31:0] in_word;
	logic [5:0]  len_inc;
	logic [31:0] put_word;
	logic [31:0] w_next;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;

	// byte count: short only on the final word, capped at four
	always_comb begin
		if (!last_word || valid_bytes > 3'd4)
			nbytes = 3'd4;
		else
			nbytes = valid_bytes;
		sts.full_word = (nbytes == 3'd4);
		len_inc       = {nbytes, 3'b000};
	end

	// clear unused bytes and place the 0x80 marker on a short final word
	always_comb begin
		unique case (nbytes)
			3'd0:    in_word = 32'h8000_0000;
			3'd1:    in_word = {message_word[31:24], 24'h80_0000};
			3'd2:    in_word = {message_word[31:16], 16'h8000};
			3'd3:    in_word = {message_word[31:8], 8'h80};
			default: in_word = message_word;
		endcase
	end

	always_comb begin
		unique case (cmd.wsel)
			WS_IN:     put_word = in_word;
			WS_PAD80:  put_word = 32'h8000_0000;
			WS_LEN_HI: put_word = len_q[63:32];
			WS_LEN_LO: put_word = len_q[31:0];
			default:   put_word = '0;
		endcase
	end

	// w_q holds W[t..t+15]; next schedule word from the rolling recurrence
	always_comb begin
		w_next = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_next = {w_next[30:0], w_next[31]};
	end

	always_comb begin
		unique case (cmd.rphase)
			RP_CH:   f_val = (b_q & (c_q ^ d_q)) ^ d_q;
			RP_MAJ:  f_val = ((b_q | c_q) & d_q) | (b_q & c_q);
			default: f_val = b_q ^ c_q ^ d_q;
		endcase
		k_val = SHA1_K[cmd.rphase];
		t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_q[0];
	end

	always_comb begin
		unique case (cmd.out_idx)
			3'd0:    digest_word = chain_q[0];
			3'd1:    digest_word = chain_q[1];
			3'd2:    digest_word = chain_q[2];
			3'd3:    digest_word = chain_q[3];
			default: digest_word = chain_q[4];
		endcase
	end

	// schedule line: message, padding and length words on put, recurrence words in rounds
	always_ff @(posedge clk) begin
		if (cmd.put || cmd.round) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= cmd.put ? put_word : w_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++)
				chain_q[i] <= SHA1_IV[i];
			a_q   <= '0;
			b_q   <= '0;
			c_q   <= '0;
			d_q   <= '0;
			e_q   <= '0;
			len_q <= '0;
		end else begin
			if (cmd.len_add)
				len_q <= len_q + {58'd0, len_inc};
			if (cmd.load_rounds) begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
				e_q <= chain_q[4];
			end else if (cmd.round) begin
				a_q <= t_val;
				b_q <= a_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				d_q <= c_q;
				e_q <= d_q;
			end
			if (cmd.add_chain) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (cmd.finish) begin
				for (int i = 0; i < 5; i++)
					chain_q[i] <= SHA1_IV[i];
				a_q   <= '0;
				b_q   <= '0;
				c_q   <= '0;
				d_q   <= '0;
				e_q   <= '0;
				len_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sha1_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_hash
// SHA-1 engine over a big-endian word stream, five-word digest out.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave side s_axis_*: one message word per handshake. tdata carries the
//    four bytes (first byte in bits 31..24), tuser the byte count, tlast
//    marks the final word; only the final word may carry fewer than four.
//  - Master side m_axis_*: five digest words after each final word, most
//    significant first; tuser gives the word index, tlast flags index 4.
//  - The sixteenth word of a block starts a compression of 80 rounds at one
//    round a cycle, followed by the chaining add.
//  - After the final word the sequencer injects the padding and length words
//    at one a cycle, with one or two compressions before the digest readout.
//  - s_axis_tready is low while a compression, padding or readout is busy.
//  - If the receiver stalls, the digest word holds until taken; once the
//    fifth is taken the state returns to the initial vector.
//  - Reset (arst_n low) loads the initial vector and clears the length.
// ----------------------------------------------------------------------------
module sha1_hash
	import sha1_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] message_word
	input  wire logic [2:0]  s_axis_tuser,   // [2:0] valid_bytes
	input  wire logic        s_axis_tlast,   // last_word
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]       m_axis_tuser,   // [2:0] word_index
	output logic             m_axis_tlast    // last_digest
);

	cmd_t cmd;
	sts_t sts;

	sha1_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sha1_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.message_word (s_axis_tdata),
		.valid_bytes  (s_axis_tuser),
		.last_word    (s_axis_tlast),
		.cmd          (cmd),
		.sts          (sts),
		.digest_word  (m_axis_tdata)
	);

	// index is held by the sequencer; last word of the digest is index four
	assign m_axis_tuser = cmd.out_idx;
	assign m_axis_tlast = (cmd.out_idx == 3'(DIGEST_LEN - 1));

endmodule
`default_nettype wire
